// ===== src/ycbrgb_pkg.sv =====
package ycbrgb_pkg;

    localparam int unsigned LUMA_COUNT = 4;

    typedef enum logic [1:0] {
        FMT_422_INTERLEAVED = 2'd0,
        FMT_420_PLANAR      = 2'd1,
        FMT_420_SEMI_CBCR   = 2'd2,
        FMT_420_SEMI_CRCB   = 2'd3
    } src_format_t;

    typedef enum logic {
        OUT_GRAY  = 1'b0,
        OUT_COLOR = 1'b1
    } out_color_t;

    typedef enum logic [0:0] {
        REG_SOURCE_FORMAT = 1'd0,
        REG_OUTPUT_COLOR  = 1'd1
    } reg_index_t;

    localparam int unsigned WR_DATA_W = 2;

    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    localparam logic signed [17:0] COEF_R_CR = 18'sd358;
    localparam logic signed [17:0] COEF_G_CB = 18'sd88;
    localparam logic signed [17:0] COEF_G_CR = 18'sd182;
    localparam logic signed [17:0] COEF_B_CB = 18'sd453;

    localparam logic [7:0] PIXEL_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] luma_0;
        logic [7:0] luma_1;
        logic [7:0] luma_2;
        logic [7:0] luma_3;
        logic [7:0] chroma_first;
        logic [7:0] chroma_second;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] gray;
        logic [1:0] slot;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [LUMA_COUNT-1:0][7:0] luma;
        logic signed [8:0]          off_r;
        logic signed [8:0]          off_g;
        logic signed [8:0]          off_b;
        logic                       color;
        logic                       four_px;
    } group_t;

    function automatic logic [7:0] clamp_add(input logic [7:0] y, input logic signed [8:0] off);
        logic signed [9:0] sum;
        logic [7:0]        res;
        sum = $signed({2'b00, y}) + 10'(off);
        if (sum < 10'sd0)
        begin
            res = 8'd0;
        end
        else if (sum > $signed({2'b00, PIXEL_MAX}))
        begin
            res = PIXEL_MAX;
        end
        else
        begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

// ===== src/ycbrgb_ifs.sv =====
interface ycbrgb_in_if;
    logic                 valid;
    logic                 ready;
    ycbrgb_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ycbrgb_out_if;
    logic                  valid;
    logic                  ready;
    ycbrgb_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ycbrgb_serial.sv =====
module ycbrgb_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_valid,
    input  ycbrgb_pkg::group_t  grp,
    output logic                grp_ready,
    ycbrgb_out_if.source        pixels
);

    logic               s3_valid_reg;
    logic               s3_valid_next;
    ycbrgb_pkg::group_t s3_grp_reg;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;

    logic                  o_valid_reg;
    logic                  o_valid_next;
    ycbrgb_pkg::out_item_t o_data_reg;
    ycbrgb_pkg::out_item_t o_data_next;

    logic       o_load;
    logic       emit;
    logic       last_px;
    logic       take;
    logic [7:0] y_sel;

    assign o_load  = !o_valid_reg || pixels.ready;
    assign emit    = s3_valid_reg && o_load;
    assign last_px = s3_grp_reg.four_px ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign take    = !s3_valid_reg || (emit && last_px);
    assign y_sel   = s3_grp_reg.luma[idx_reg];

    assign grp_ready      = take;
    assign pixels.valid   = o_valid_reg;
    assign pixels.payload = o_data_reg;

    always_comb
    begin
        s3_valid_next = s3_valid_reg;
        idx_next      = idx_reg;
        if (take)
        begin
            s3_valid_next = grp_valid;
            idx_next      = 2'd0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        o_valid_next = o_load ? s3_valid_reg : o_valid_reg;
        o_data_next  = o_data_reg;
        if (emit)
        begin
            o_data_next.gray = y_sel;
            o_data_next.slot = idx_reg;
            o_data_next.last = last_px;
            if (s3_grp_reg.color == ycbrgb_pkg::OUT_COLOR)
            begin
                o_data_next.red   = ycbrgb_pkg::clamp_add(y_sel, s3_grp_reg.off_r);
                o_data_next.green = ycbrgb_pkg::clamp_add(y_sel, s3_grp_reg.off_g);
                o_data_next.blue  = ycbrgb_pkg::clamp_add(y_sel, s3_grp_reg.off_b);
            end
            else
            begin
                o_data_next.red   = y_sel;
                o_data_next.green = y_sel;
                o_data_next.blue  = y_sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            idx_reg      <= 2'd0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            idx_reg      <= idx_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && grp_valid)
        begin
            s3_grp_reg <= grp;
        end
        o_data_reg <= o_data_next;
    end

    a_two_slots_422: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_grp_reg.four_px |-> idx_reg <= 2'd1)
        else $error("4:2:2 group reached a bottom-row slot");

    a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> o_valid_reg)
        else $error("emitted pixel did not reach the output register");

    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !last_px |=> s3_valid_reg && idx_reg == 2'($past(idx_reg) + 2'd1))
        else $error("pixel slot did not advance after a transaction");

endmodule

// ===== src/ycbcr_block_to_rgb_core.sv =====
// An input group is registered in turn at capture, multiply, serializer, output.
// A group yields two pixels in 4:2:2 and four in 4:2:0 on the single pixel output
// channel, one pixel per cycle unless pixels.ready stalls; later groups queue up.
// Stages: input capture, chroma multiply, pixel serializer, clamp and output register.
// Reset: asynchronous active low; empties the pipeline, format 4:2:2, color output.
module ycbcr_block_to_rgb_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [0:0]                        wr_index,
    input  logic [ycbrgb_pkg::WR_DATA_W-1:0]  wr_data,
    ycbrgb_in_if.sink                         samples,
    ycbrgb_out_if.source                      pixels
);

    ycbrgb_pkg::src_format_t source_format_reg;
    ycbrgb_pkg::src_format_t source_format_next;
    ycbrgb_pkg::out_color_t  output_color_reg;
    ycbrgb_pkg::out_color_t  output_color_next;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [3:0][7:0]         s1_luma_reg;
    logic signed [7:0]       s1_cb_reg;
    logic signed [7:0]       s1_cr_reg;
    logic                    s1_color_reg;
    logic                    s1_four_reg;

    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    ycbrgb_pkg::group_t      s2_grp_reg;
    ycbrgb_pkg::group_t      s2_grp_next;

    logic                    s1_ready;
    logic                    s2_ready;
    logic                    grp_ready;
    logic                    in_fire;
    logic signed [7:0]       c1;
    logic signed [7:0]       c2;
    logic signed [17:0]      prod_r;
    logic signed [17:0]      prod_g;
    logic signed [17:0]      prod_b;

    always_comb
    begin
        source_format_next = source_format_reg;
        output_color_next  = output_color_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                ycbrgb_pkg::REG_SOURCE_FORMAT:
                    source_format_next = ycbrgb_pkg::src_format_t'(wr_data[1:0]);
                ycbrgb_pkg::REG_OUTPUT_COLOR:
                    output_color_next = ycbrgb_pkg::out_color_t'(wr_data[0]);
                default: ;
            endcase
        end
    end

    assign s2_ready      = !s2_valid_reg || grp_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign samples.ready = s1_ready;
    assign in_fire       = samples.valid && s1_ready;

    assign c1 = $signed(samples.payload.chroma_first ^ ycbrgb_pkg::CHROMA_OFFSET);
    assign c2 = $signed(samples.payload.chroma_second ^ ycbrgb_pkg::CHROMA_OFFSET);

    assign s1_valid_next = s1_ready ? samples.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    assign prod_r = 18'(s1_cr_reg) * ycbrgb_pkg::COEF_R_CR;
    assign prod_g = 18'(s1_cb_reg) * ycbrgb_pkg::COEF_G_CB
                  + 18'(s1_cr_reg) * ycbrgb_pkg::COEF_G_CR;
    assign prod_b = 18'(s1_cb_reg) * ycbrgb_pkg::COEF_B_CB;

    always_comb
    begin
        s2_grp_next.luma    = s1_luma_reg;
        s2_grp_next.off_r   = prod_r[16:8];
        s2_grp_next.off_g   = -prod_g[16:8];
        s2_grp_next.off_b   = prod_b[16:8];
        s2_grp_next.color   = s1_color_reg;
        s2_grp_next.four_px = s1_four_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= ycbrgb_pkg::FMT_422_INTERLEAVED;
            output_color_reg  <= ycbrgb_pkg::OUT_COLOR;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
        end
        else
        begin
            source_format_reg <= source_format_next;
            output_color_reg  <= output_color_next;
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_luma_reg[0] <= samples.payload.luma_0;
            s1_luma_reg[1] <= samples.payload.luma_1;
            s1_luma_reg[2] <= samples.payload.luma_2;
            s1_luma_reg[3] <= samples.payload.luma_3;
            s1_color_reg   <= (output_color_reg == ycbrgb_pkg::OUT_COLOR);
            s1_four_reg    <= (source_format_reg != ycbrgb_pkg::FMT_422_INTERLEAVED);
            if (source_format_reg == ycbrgb_pkg::FMT_420_SEMI_CRCB)
            begin
                s1_cb_reg <= c2;
                s1_cr_reg <= c1;
            end
            else
            begin
                s1_cb_reg <= c1;
                s1_cr_reg <= c2;
            end
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_grp_reg <= s2_grp_next;
        end
    end

    ycbrgb_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (s2_valid_reg),
        .grp       (s2_grp_reg),
        .grp_ready (grp_ready),
        .pixels    (pixels)
    );

endmodule
